[hdl/cfp_pkg.sv]
// shared types, widths and character codes of the formula parser
package cfp_pkg;

    localparam int DEF_MAX_ELEMENTS = 16;
    localparam int DEF_NAME_LIMIT   = 16;
    localparam int SLOT_LIMIT       = 16;

    localparam int SYM_W   = 14;
    localparam int CHAR_W  = 7;
    localparam int MASS_W  = 24;
    localparam int CNT_W   = 7;
    localparam int MULT_W  = 4;
    localparam int ACC_W   = 32;
    localparam int PROD_W  = MASS_W + MULT_W;
    localparam int POS_W   = 5;
    localparam int CFG_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int DIST_W  = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CHAR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 7'h7A;

    localparam logic [1:0] MODE_SCAN    = 2'd0;
    localparam logic [1:0] MODE_PENDING = 2'd1;
    localparam logic [1:0] MODE_AFTER   = 2'd2;
    localparam logic [1:0] MODE_STOP    = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_LONG    = 2'd2;

    localparam logic signed [1:0] CHARGE_POS  = 2'sb01;
    localparam logic signed [1:0] CHARGE_NEG  = 2'sb11;
    localparam logic signed [1:0] CHARGE_NONE = 2'sb00;

    typedef struct packed {
        logic              found;
        logic              was_zero;
        logic [MASS_W-1:0] mass;
    } t_chain;

endpackage

[hdl/chemical_formula_parser.sv]
// top level of the species formula parser
//
// Items are taken one per cycle while the parser is in its run state: a
// table load (tuser 0) writes one element entry, a formula character
// (tuser 1) is matched against all entries at once through the row of
// element cells, lowest matching entry first. After the item with tlast the
// block passes through a flush state that closes the name and a drain state
// that lets the mass adder finish, then shifts one result per configured
// element out of the cell row, one per cycle while m_axis_tready is high. No
// input is taken while results are going out. The table has no reset;
// entries must be loaded before a formula uses them. Atom counts and mass
// saturate. Configuration writes are taken at any time but belong to idle
// periods.
module chemical_formula_parser #(
    parameter int MAX_ELEMENTS = cfp_pkg::DEF_MAX_ELEMENTS,
    parameter int NAME_LIMIT   = cfp_pkg::DEF_NAME_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: element_count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index, symbol_first, symbol_second, atomic_mass, formula_char
    input  logic [55:0] s_axis_tdata,
    // func
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // element_slot, atom_count, species_mass, species_charge,
    // distinct_elements, parse_status
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import cfp_pkg::*;

    localparam int NUM_CELLS = (MAX_ELEMENTS < SLOT_LIMIT) ? MAX_ELEMENTS : SLOT_LIMIT;
    localparam logic [CFG_W-1:0] CELLS_V  = CFG_W'(NUM_CELLS);
    localparam logic [POS_W-1:0] LONG_POS = POS_W'(NAME_LIMIT - 1);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [SYM_W-1:0]  r_pending, n_pending;
    logic [POS_W-1:0]  r_pos;
    logic signed [1:0] r_charge, n_charge;
    logic              r_unknown, r_long, n_long;
    logic [DIST_W-1:0] r_distinct;
    logic [CFG_W-1:0]  r_eff;
    logic [SLOT_W-1:0] r_slot;

    logic              w_in_acc, w_char_acc, w_step, w_out_acc, w_done;
    logic [CHAR_W-1:0] w_c;
    logic              w_is_digit, w_is_lower, w_is_end;
    logic              w_do_scan, w_do_after, w_commit;
    logic [MULT_W-1:0] w_mult;
    logic signed [1:0] w_charge_c;
    logic [ACC_W-1:0]  w_acc;
    logic [1:0]        w_status;

    t_chain            w_chain [NUM_CELLS+1];
    logic [CNT_W-1:0]  w_cnt   [NUM_CELLS+1];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_RUN);
    assign m_axis_tvalid = (r_state == S_EMIT);

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_char_acc = w_in_acc && (s_axis_tuser == FUNC_CHAR);
    assign w_step     = w_char_acc || (r_state == S_FLUSH);
    assign w_out_acc  = m_axis_tvalid && m_axis_tready;
    assign w_done     = w_out_acc && m_axis_tlast;

    assign w_c        = (r_state == S_FLUSH) ? CH_NUL : s_axis_tdata[48:42];
    assign w_is_digit = (w_c > CH_ONE) && (w_c <= CH_NINE);
    assign w_is_lower = (w_c >= CH_LO_A) && (w_c <= CH_LO_Z);
    assign w_is_end   = (w_c == CH_PLUS) || (w_c == CH_MINUS) || (w_c == CH_NUL);
    assign w_charge_c = (w_c == CH_PLUS) ? CHARGE_POS :
                        ((w_c == CH_MINUS) ? CHARGE_NEG : CHARGE_NONE);

    always_comb begin
        n_mode     = r_mode;
        n_pending  = r_pending;
        n_charge   = r_charge;
        n_long     = r_long;
        w_do_scan  = 1'b0;
        w_do_after = 1'b0;
        w_commit   = 1'b0;
        w_mult     = MULT_W'(1);
        if (w_step) begin
            unique case (r_mode)
                MODE_SCAN: begin
                    w_do_scan = 1'b1;
                end
                MODE_PENDING: begin
                    if (w_is_lower) begin
                        n_pending = {r_pending[SYM_W-1:CHAR_W], w_c};
                        n_mode    = MODE_AFTER;
                    end else begin
                        w_do_after = 1'b1;
                    end
                end
                MODE_AFTER: begin
                    w_do_after = 1'b1;
                end
                default: begin
                end
            endcase
            if (w_do_after) begin
                w_commit = 1'b1;
                if (w_is_digit) begin
                    w_mult = w_c[MULT_W-1:0];
                    n_mode = MODE_SCAN;
                end else begin
                    w_do_scan = 1'b1;
                end
            end
            if (w_do_scan) begin
                if (r_pos >= LONG_POS) begin
                    n_long   = 1'b1;
                    n_charge = w_charge_c;
                    n_mode   = MODE_STOP;
                end else if (w_is_end) begin
                    n_charge = w_charge_c;
                    n_mode   = MODE_STOP;
                end else begin
                    n_pending = {w_c, CHAR_W'(0)};
                    n_mode    = MODE_PENDING;
                end
            end
        end
    end

    assign w_chain[0]       = '0;
    assign w_cnt[NUM_CELLS] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        cfp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (CFG_W'(k) < r_eff),
            .i_wr      (w_in_acc && (s_axis_tuser == FUNC_LOAD) &&
                        (s_axis_tdata[3:0] == SLOT_W'(k))),
            .i_wr_sym  ({s_axis_tdata[10:4], s_axis_tdata[17:11]}),
            .i_wr_mass (s_axis_tdata[41:18]),
            .i_cmp_sym (r_pending),
            .i_commit  (w_commit),
            .i_mult    (w_mult),
            .i_shift   (w_out_acc),
            .i_count   (w_cnt[k+1]),
            .i_chain   (w_chain[k]),
            .o_chain   (w_chain[k+1]),
            .o_count   (w_cnt[k])
        );
    end

    cfp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_commit && w_chain[NUM_CELLS].found),
        .i_mult  (w_mult),
        .i_mass  (w_chain[NUM_CELLS].mass),
        .i_clear (w_done),
        .o_acc   (w_acc)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_char_acc && s_axis_tlast) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_DRAIN;
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (w_done) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_mode     <= MODE_SCAN;
            r_pending  <= '0;
            r_pos      <= '0;
            r_charge   <= CHARGE_NONE;
            r_unknown  <= 1'b0;
            r_long     <= 1'b0;
            r_distinct <= '0;
            r_eff      <= CFG_W'(1);
            r_slot     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_data == '0) begin
                    r_eff <= CFG_W'(1);
                end else if (i_cfg_data > CELLS_V) begin
                    r_eff <= CELLS_V;
                end else begin
                    r_eff <= i_cfg_data;
                end
            end
            if (w_done) begin
                r_mode     <= MODE_SCAN;
                r_pending  <= '0;
                r_pos      <= '0;
                r_charge   <= CHARGE_NONE;
                r_unknown  <= 1'b0;
                r_long     <= 1'b0;
                r_distinct <= '0;
                r_slot     <= '0;
            end else begin
                r_mode    <= n_mode;
                r_pending <= n_pending;
                r_charge  <= n_charge;
                r_long    <= n_long;
                if (w_char_acc && (r_pos != POS_MAX)) begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (w_commit) begin
                    if (!w_chain[NUM_CELLS].found) begin
                        r_unknown <= 1'b1;
                    end else if (w_chain[NUM_CELLS].was_zero) begin
                        r_distinct <= r_distinct + DIST_W'(1);
                    end
                end
                if (w_out_acc) begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
        end
    end

    assign w_status     = r_long ? STATUS_LONG : (r_unknown ? STATUS_UNKNOWN : STATUS_OK);
    assign m_axis_tlast = (({1'b0, r_slot} + CFG_W'(1)) == r_eff);
    assign m_axis_tdata = {4'b0, w_status, r_distinct, r_charge, w_acc, w_cnt[0], r_slot};

`ifndef ASSERT_OFF
    a_last_char_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_char_acc && s_axis_tlast |=> r_state == S_FLUSH)
        else $error("final character did not start the flush");

    a_emit_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_mode == MODE_STOP)
        else $error("results shown while parsing is still open");

    a_distinct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_distinct <= r_eff)
        else $error("more distinct elements than table entries");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> w_acc == '0 && r_distinct == '0 && r_pos == '0)
        else $error("formula state not cleared after the last result");
`endif

endmodule

[hdl/cfp_cell.sv]
// one table entry of the parser: symbol, mass and atom count
module cfp_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_wr,
    input  logic [cfp_pkg::SYM_W-1:0]   i_wr_sym,
    input  logic [cfp_pkg::MASS_W-1:0]  i_wr_mass,
    input  logic [cfp_pkg::SYM_W-1:0]   i_cmp_sym,
    input  logic                        i_commit,
    input  logic [cfp_pkg::MULT_W-1:0]  i_mult,
    input  logic                        i_shift,
    input  logic [cfp_pkg::CNT_W-1:0]   i_count,
    input  cfp_pkg::t_chain             i_chain,
    output cfp_pkg::t_chain             o_chain,
    output logic [cfp_pkg::CNT_W-1:0]   o_count
);
    import cfp_pkg::*;

    logic [SYM_W-1:0]  r_sym;
    logic [MASS_W-1:0] r_mass;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W:0]    w_sum;
    logic              w_match;
    logic              w_hit;

    assign w_match = i_en && (r_sym == i_cmp_sym);
    assign w_hit   = w_match && !i_chain.found;
    assign w_sum   = {1'b0, r_count} + (CNT_W + 1)'(i_mult);

    assign o_chain.found    = i_chain.found | w_match;
    assign o_chain.was_zero = i_chain.was_zero | (w_hit && (r_count == '0));
    assign o_chain.mass     = i_chain.mass | (w_hit ? r_mass : '0);
    assign o_count          = r_count;

    always_comb begin
        n_count = r_count;
        if (i_shift) begin
            n_count = i_count;
        end else if (i_commit && w_hit) begin
            n_count = w_sum[CNT_W] ? CNT_MAX : w_sum[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sym  <= i_wr_sym;
            r_mass <= i_wr_mass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[hdl/cfp_accum.sv]
// species mass accumulator: registered operands, then product and saturating add
module cfp_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [cfp_pkg::MULT_W-1:0]  i_mult,
    input  logic [cfp_pkg::MASS_W-1:0]  i_mass,
    input  logic                        i_clear,
    output logic [cfp_pkg::ACC_W-1:0]   o_acc
);
    import cfp_pkg::*;

    logic              r_valid;
    logic [MULT_W-1:0] r_mult;
    logic [MASS_W-1:0] r_mass;
    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0] w_prod;
    logic [ACC_W:0]    w_sum;

    assign w_prod = PROD_W'(r_mult) * PROD_W'(r_mass);
    assign w_sum  = {1'b0, r_acc} + (ACC_W + 1)'(w_prod);
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        r_mult <= i_mult;
        r_mass <= i_mass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_valid <= i_valid;
            if (r_valid) begin
                r_acc <= w_sum[ACC_W] ? '1 : w_sum[ACC_W-1:0];
            end
        end
    end

endmodule
